@@ rtl/hmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// hmrs_pkg
// Shared types and constants of the hashed move rating statistics table.
// ----------------------------------------------------------------------------
package hmrs_pkg;

  localparam int ENTRIES_DEF = 4096;

  localparam int KEY_W    = 64;
  localparam int MOVE_W   = 16;
  localparam int CNT_W    = 15;
  localparam int SUM_W    = 26;
  localparam int SQ_W     = 38;
  localparam int RAT_W    = 12;
  localparam int GAME_W   = 16;
  localparam int IDXO_W   = 12;
  localparam int ARITH_W  = 64;
  localparam int DIVR_W   = 32;
  localparam int REM_W    = 34;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [RAT_W-1:0] RATING_CAP    = 12'd4000;
  localparam logic [CNT_W-1:0] COUNT_CAP     = 15'd32767;
  localparam logic [CNT_W-1:0] THRESH_RST    = 15'd16384;
  localparam logic [CNT_W-1:0] MIN_GAMES_RST = 15'd10;

  typedef enum logic [1:0] {
    ST_RECORDED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_EXACT  = 2'd1,
    REG_MIN    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MOVE_W-1:0] move;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [RAT_W-1:0]  lo;
    logic [RAT_W-1:0]  hi;
    logic              term;
    logic [GAME_W-1:0] game;
  } entry_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [ARITH_W-1:0] a;
    logic [DIVR_W-1:0]  b;
  } arith_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ARITH_W-1:0] quo;
    logic [REM_W-1:0]   rem;
  } arith_rsp_t;

endpackage

@@ rtl/hashed_move_rating_stats_table.sv @@
// ----------------------------------------------------------------------------
// hashed_move_rating_stats_table
// Open-addressed (position key, move) table with per-entry rating statistics.
// ----------------------------------------------------------------------------
// Input channel (in_*, valid/ready): one record or query per transfer. The
// block takes one item at a time; in_ready is high only while the sequencer
// is idle. Output channel (out_*, valid/ready): one result per item, held in
// an output register, so the next item is taken while a result still waits.
// Steps per item: take the transfer, hash the key through the divider when
// 2*ENTRIES is not a power of two, and probe from the home slot until a
// match or an empty slot ends the walk. For a record, update the entry and,
// when the count reaches the threshold, walk from the home slot again to
// halve every entry with the same position key, up to the empty slot that
// ends the walk. Then report and, for a non-zero count, divide twice on the
// shared divide/sqrt unit, form the variance, take its square root on the
// same unit when positive, then load the result; misses go straight to load.
// After reset the slot table is cleared one slot a cycle (2*ENTRIES slots,
// 8192 by default) while in_ready stays low; APB writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the block then
// waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module hashed_move_rating_stats_table #(
  parameter int ENTRIES = hmrs_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [hmrs_pkg::KEY_W-1:0]      in_position_key,
  input  logic [hmrs_pkg::MOVE_W-1:0]     in_move_code,
  input  logic signed [12:0]              in_player_rating,
  input  logic [hmrs_pkg::GAME_W-1:0]     in_game_number,
  input  logic                            in_last_of_game,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [hmrs_pkg::IDXO_W-1:0]     out_entry_index,
  output logic [hmrs_pkg::CNT_W-1:0]      out_occurrence_count,
  output logic [hmrs_pkg::RAT_W-1:0]      out_mean_rating,
  output logic [hmrs_pkg::RAT_W-1:0]      out_rating_deviation,
  output logic [hmrs_pkg::RAT_W-1:0]      out_lowest_rating,
  output logic [hmrs_pkg::RAT_W-1:0]      out_highest_rating,
  output logic                            out_is_terminal,
  output logic [hmrs_pkg::GAME_W-1:0]     out_stored_game,
  output logic                            out_qualifies,
  output logic                            out_halved,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hmrs_pkg::PADDR_W-1:0]    paddr,
  input  logic [hmrs_pkg::PDATA_W-1:0]    pwdata,
  output logic [hmrs_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int SLOTS      = 2 * ENTRIES;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int SV_W       = $clog2(ENTRIES + 1);
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int ENTRY_W    = $bits(hmrs_pkg::entry_t);

  typedef enum logic [18:0] {
    S_CLEAR    = 19'h00001,
    S_IDLE     = 19'h00002,
    S_HASH     = 19'h00004,
    S_SLOT_RD  = 19'h00008,
    S_SLOT_CHK = 19'h00010,
    S_ENT_CHK  = 19'h00020,
    S_SQR      = 19'h00040,
    S_UPD      = 19'h00080,
    S_HV_RD    = 19'h00100,
    S_HV_CHK   = 19'h00200,
    S_HV_ENT   = 19'h00400,
    S_TERM     = 19'h00800,
    S_REPORT   = 19'h01000,
    S_MEAN     = 19'h02000,
    S_MS       = 19'h04000,
    S_MSQ      = 19'h08000,
    S_VAR      = 19'h10000,
    S_SQRT     = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [hmrs_pkg::CNT_W-1:0] thr_r;
  logic                       exact_r;
  logic [hmrs_pkg::CNT_W-1:0] min_r;

  // item context
  logic                          action_r;
  logic [hmrs_pkg::KEY_W-1:0]    key_r;
  logic [hmrs_pkg::MOVE_W-1:0]   move_r;
  logic                          rated_r;
  logic [hmrs_pkg::RAT_W-1:0]    rate_r;
  logic [hmrs_pkg::GAME_W-1:0]   game_r;
  logic                          last_r;
  logic                          halved_r;
  logic                          zero_r;
  hmrs_pkg::status_t             status_r;

  logic [SLOT_W-1:0]             home_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [SLOT_W-1:0]             clr_r;
  logic [IDX_W-1:0]              idx_r;
  logic [IDX_W-1:0]              e_r;
  logic [SV_W-1:0]               fill_r;
  hmrs_pkg::entry_t              cur_r;
  logic [hmrs_pkg::RAT_W-1:0]    mean_r;
  logic [hmrs_pkg::RAT_W-1:0]    dev_r;
  logic [hmrs_pkg::SQ_W-1:0]     ms_r;
  logic [23:0]                   prod_r;
  logic [hmrs_pkg::RAT_W-1:0]    mul_in;

  // output register
  logic                          out_valid_r;
  logic [1:0]                    o_status_r;
  logic [hmrs_pkg::IDXO_W-1:0]   o_idx_r;
  logic [hmrs_pkg::CNT_W-1:0]    o_cnt_r;
  logic [hmrs_pkg::RAT_W-1:0]    o_mean_r;
  logic [hmrs_pkg::RAT_W-1:0]    o_dev_r;
  logic [hmrs_pkg::RAT_W-1:0]    o_lo_r;
  logic [hmrs_pkg::RAT_W-1:0]    o_hi_r;
  logic                          o_term_r;
  logic [hmrs_pkg::GAME_W-1:0]   o_game_r;
  logic                          o_qual_r;
  logic                          o_halved_r;

  // memories
  logic                          slot_we;
  logic [SLOT_W-1:0]             slot_waddr;
  logic [SV_W-1:0]               slot_wdata;
  logic [SV_W-1:0]               slot_rdata;
  logic [SV_W-1:0]               slot_m1;
  logic                          ent_we;
  logic [IDX_W-1:0]              ent_waddr;
  hmrs_pkg::entry_t              ent_wdata;
  logic [ENTRY_W-1:0]            ent_rbits;
  hmrs_pkg::entry_t              ent_rdata;
  logic [IDX_W-1:0]              ent_raddr;

  hmrs_pkg::arith_req_t          ar_req;
  hmrs_pkg::arith_rsp_t          ar_rsp;

  hmrs_pkg::entry_t              cur_new;
  hmrs_pkg::entry_t              cur_upd;
  hmrs_pkg::entry_t              cur_term;
  hmrs_pkg::entry_t              ent_half;
  logic [hmrs_pkg::SUM_W:0]      sum_ext;
  logic [hmrs_pkg::SQ_W:0]       sq_ext;
  logic [hmrs_pkg::CNT_W:0]      cnt_h;
  logic [hmrs_pkg::SUM_W:0]      sum_h;
  logic [hmrs_pkg::SQ_W:0]       sq_h;
  logic [SLOT_W-1:0]             slot_next;
  logic                          in_xfer;
  logic                          out_load;
  logic                          key_hit;
  logic                          qual;
  logic [31:0]                   e32;
  logic [hmrs_pkg::RAT_W:0]      rating_u;
  logic [hmrs_pkg::SQ_W-1:0]     var_val;

  hmrs_ram #(.WIDTH(SV_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_r),
    .rdata (slot_rdata)
  );

  hmrs_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rbits)
  );

  hmrs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .rsp   (ar_rsp)
  );

  assign ent_rdata = hmrs_pkg::entry_t'(ent_rbits);
  assign slot_m1   = slot_rdata - SV_W'(1);
  assign ent_raddr = slot_m1[IDX_W-1:0];
  assign slot_next = (slot_r == SLOT_W'(SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign key_hit   = (ent_rdata.key == key_r);
  assign mul_in    = (state_r == S_MSQ) ? mean_r : rate_r;
  assign rating_u  = in_player_rating;
  assign var_val   = ms_r - hmrs_pkg::SQ_W'(prod_r);
  assign e32       = 32'(e_r);

  // fresh entry
  always_comb begin
    cur_new      = '0;
    cur_new.key  = key_r;
    cur_new.move = move_r;
    cur_new.lo   = hmrs_pkg::RATING_CAP;
  end

  // statistics update for a rated record
  always_comb begin
    cur_upd = cur_r;
    sum_ext = {1'b0, cur_r.sum} + (hmrs_pkg::SUM_W+1)'(rate_r);
    sq_ext  = {1'b0, cur_r.sq} + (hmrs_pkg::SQ_W+1)'(prod_r);
    if (rated_r) begin
      if (cur_r.count < hmrs_pkg::COUNT_CAP) begin
        cur_upd.count = cur_r.count + hmrs_pkg::CNT_W'(1);
      end
      cur_upd.sum = sum_ext[hmrs_pkg::SUM_W] ? '1 : sum_ext[hmrs_pkg::SUM_W-1:0];
      cur_upd.sq  = sq_ext[hmrs_pkg::SQ_W] ? '1 : sq_ext[hmrs_pkg::SQ_W-1:0];
      if (rate_r < cur_r.lo) begin
        cur_upd.lo = rate_r;
      end
      if (rate_r > cur_r.hi) begin
        cur_upd.hi = rate_r;
      end
      cur_upd.game = game_r;
    end
  end

  always_comb begin
    cur_term      = cur_r;
    cur_term.term = cur_r.term | last_r;
  end

  // halving, rounding up
  always_comb begin
    cnt_h          = {1'b0, ent_rdata.count} + (hmrs_pkg::CNT_W+1)'(1);
    sum_h          = {1'b0, ent_rdata.sum} + (hmrs_pkg::SUM_W+1)'(1);
    sq_h           = {1'b0, ent_rdata.sq} + (hmrs_pkg::SQ_W+1)'(1);
    ent_half       = ent_rdata;
    ent_half.count = cnt_h[hmrs_pkg::CNT_W:1];
    ent_half.sum   = sum_h[hmrs_pkg::SUM_W:1];
    ent_half.sq    = sq_h[hmrs_pkg::SQ_W:1];
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = fill_r + SV_W'(1);
    if (state_r == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_r;
      slot_wdata = '0;
    end else if (state_r == S_SLOT_CHK && slot_rdata == '0 && !action_r &&
                 fill_r < SV_W'(ENTRIES)) begin
      slot_we = 1'b1;
    end
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = e_r;
    ent_wdata = cur_upd;
    unique case (state_r)
      S_UPD: begin
        ent_we = 1'b1;
      end
      S_HV_ENT: begin
        ent_we    = key_hit;
        ent_waddr = idx_r;
        ent_wdata = ent_half;
      end
      S_TERM: begin
        ent_we    = 1'b1;
        ent_wdata = cur_term;
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = hmrs_pkg::OP_DIV;
    ar_req.a     = '0;
    ar_req.b     = '0;
    unique case (state_r)
      S_IDLE: begin
        ar_req.start = in_xfer && !SLOTS_POW2;
        ar_req.a     = in_position_key;
        ar_req.b     = hmrs_pkg::DIVR_W'(SLOTS);
      end
      S_REPORT: begin
        ar_req.start = (cur_r.count != '0);
        ar_req.a     = hmrs_pkg::ARITH_W'(cur_r.sum);
        ar_req.b     = hmrs_pkg::DIVR_W'(cur_r.count);
      end
      S_MEAN: begin
        ar_req.start = ar_rsp.done;
        ar_req.a     = hmrs_pkg::ARITH_W'(cur_r.sq);
        ar_req.b     = hmrs_pkg::DIVR_W'(cur_r.count);
      end
      S_VAR: begin
        ar_req.start = (ms_r > hmrs_pkg::SQ_W'(prod_r));
        ar_req.op    = hmrs_pkg::OP_SQRT;
        ar_req.a     = hmrs_pkg::ARITH_W'(var_val);
      end
      default: begin
        ar_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:     if (in_xfer) state_nxt = SLOTS_POW2 ? S_SLOT_RD : S_HASH;
      S_HASH:     if (ar_rsp.done) state_nxt = S_SLOT_RD;
      S_SLOT_RD:  state_nxt = S_SLOT_CHK;
      S_SLOT_CHK: begin
        if (slot_rdata != '0) begin
          state_nxt = S_ENT_CHK;
        end else if (action_r || fill_r >= SV_W'(ENTRIES)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_ENT_CHK: begin
        if (key_hit && ent_rdata.move == move_r) begin
          state_nxt = action_r ? S_REPORT : S_SQR;
        end else begin
          state_nxt = S_SLOT_RD;
        end
      end
      S_SQR:      state_nxt = S_UPD;
      S_UPD:      state_nxt = (cur_upd.count >= thr_r) ? S_HV_RD : S_TERM;
      S_HV_RD:    state_nxt = S_HV_CHK;
      S_HV_CHK:   state_nxt = (slot_rdata == '0) ? S_TERM : S_HV_ENT;
      S_HV_ENT:   state_nxt = S_HV_RD;
      S_TERM:     state_nxt = S_REPORT;
      S_REPORT:   state_nxt = (cur_r.count == '0) ? S_DONE : S_MEAN;
      S_MEAN:     if (ar_rsp.done) state_nxt = S_MS;
      S_MS:       if (ar_rsp.done) state_nxt = S_MSQ;
      S_MSQ:      state_nxt = S_VAR;
      S_VAR:      state_nxt = (ms_r > hmrs_pkg::SQ_W'(prod_r)) ? S_SQRT : S_DONE;
      S_SQRT:     if (ar_rsp.done) state_nxt = S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (slot_we && state_r == S_SLOT_CHK) begin
        fill_r <= fill_r + SV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= hmrs_pkg::THRESH_RST;
      exact_r <= 1'b0;
      min_r   <= hmrs_pkg::MIN_GAMES_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        hmrs_pkg::REG_THRESH: thr_r   <= pwdata[hmrs_pkg::CNT_W-1:0];
        hmrs_pkg::REG_EXACT:  exact_r <= pwdata[0];
        hmrs_pkg::REG_MIN:    min_r   <= pwdata[hmrs_pkg::CNT_W-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hmrs_pkg::REG_THRESH: prdata = hmrs_pkg::PDATA_W'(thr_r);
      hmrs_pkg::REG_EXACT:  prdata = hmrs_pkg::PDATA_W'(exact_r);
      hmrs_pkg::REG_MIN:    prdata = hmrs_pkg::PDATA_W'(min_r);
      default:              prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_in * mul_in;
    unique case (state_r)
      S_IDLE: begin
        action_r <= in_action;
        key_r    <= in_position_key;
        move_r   <= in_move_code;
        rated_r  <= !in_player_rating[12];
        rate_r   <= (rating_u[11:0] > hmrs_pkg::RATING_CAP) ? hmrs_pkg::RATING_CAP
                                                            : rating_u[11:0];
        game_r   <= in_game_number;
        last_r   <= in_last_of_game;
        halved_r <= 1'b0;
        zero_r   <= 1'b0;
        status_r <= in_action ? hmrs_pkg::ST_FOUND : hmrs_pkg::ST_RECORDED;
        mean_r   <= '0;
        dev_r    <= '0;
        home_r   <= in_position_key[SLOT_W-1:0];
        slot_r   <= in_position_key[SLOT_W-1:0];
      end
      S_HASH: begin
        home_r <= ar_rsp.rem[SLOT_W-1:0];
        slot_r <= ar_rsp.rem[SLOT_W-1:0];
      end
      S_SLOT_CHK: begin
        idx_r <= ent_raddr;
        if (slot_rdata == '0) begin
          if (action_r) begin
            zero_r   <= 1'b1;
            status_r <= hmrs_pkg::ST_MISSING;
          end else if (fill_r >= SV_W'(ENTRIES)) begin
            zero_r   <= 1'b1;
            status_r <= hmrs_pkg::ST_FULL;
          end else begin
            e_r   <= fill_r[IDX_W-1:0];
            cur_r <= cur_new;
          end
        end
      end
      S_ENT_CHK: begin
        if (key_hit && ent_rdata.move == move_r) begin
          e_r   <= idx_r;
          cur_r <= ent_rdata;
        end else begin
          slot_r <= slot_next;
        end
      end
      S_UPD: begin
        cur_r <= cur_upd;
        if (cur_upd.count >= thr_r) begin
          halved_r <= 1'b1;
          slot_r   <= home_r;
        end
      end
      S_HV_CHK: begin
        idx_r <= ent_raddr;
      end
      S_HV_ENT: begin
        if (key_hit && idx_r == e_r) begin
          cur_r <= ent_half;
        end
        slot_r <= slot_next;
      end
      S_TERM: begin
        cur_r <= cur_term;
      end
      S_MEAN: begin
        if (ar_rsp.done) begin
          mean_r <= (ar_rsp.quo > hmrs_pkg::ARITH_W'(hmrs_pkg::RATING_CAP))
                    ? hmrs_pkg::RATING_CAP : ar_rsp.quo[hmrs_pkg::RAT_W-1:0];
        end
      end
      S_MS: begin
        if (ar_rsp.done) begin
          ms_r <= ar_rsp.quo[hmrs_pkg::SQ_W-1:0];
        end
      end
      S_SQRT: begin
        if (ar_rsp.done) begin
          dev_r <= (ar_rsp.quo > hmrs_pkg::ARITH_W'(hmrs_pkg::RATING_CAP))
                   ? hmrs_pkg::RATING_CAP : ar_rsp.quo[hmrs_pkg::RAT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign qual = !zero_r && (exact_r ? (cur_r.count != '0) : (cur_r.count > min_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= status_r;
      o_qual_r   <= qual;
      if (zero_r) begin
        o_idx_r    <= '0;
        o_cnt_r    <= '0;
        o_mean_r   <= '0;
        o_dev_r    <= '0;
        o_lo_r     <= '0;
        o_hi_r     <= '0;
        o_term_r   <= 1'b0;
        o_game_r   <= '0;
        o_halved_r <= 1'b0;
      end else begin
        o_idx_r    <= e32[hmrs_pkg::IDXO_W-1:0];
        o_cnt_r    <= cur_r.count;
        o_mean_r   <= mean_r;
        o_dev_r    <= dev_r;
        o_lo_r     <= cur_r.lo;
        o_hi_r     <= cur_r.hi;
        o_term_r   <= cur_r.term;
        o_game_r   <= cur_r.game;
        o_halved_r <= halved_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_entry_index      = o_idx_r;
  assign out_occurrence_count = o_cnt_r;
  assign out_mean_rating      = o_mean_r;
  assign out_rating_deviation = o_dev_r;
  assign out_lowest_rating    = o_lo_r;
  assign out_highest_rating   = o_hi_r;
  assign out_is_terminal      = o_term_r;
  assign out_stored_game      = o_game_r;
  assign out_qualifies        = o_qual_r;
  assign out_halved           = o_halved_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SV_W'(ENTRIES))
    else $error("fill level beyond capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == hmrs_pkg::ST_MISSING || out_status == hmrs_pkg::ST_FULL)
    |-> out_entry_index == '0 && out_occurrence_count == '0 && !out_qualifies)
    else $error("miss or full result carries entry data");

  a_halved_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halved |-> out_status == hmrs_pkg::ST_RECORDED)
    else $error("halved flag on a non-record result");

  a_arith_start: assert property (@(posedge clk) disable iff (!rst_n)
    ar_req.start |-> !ar_rsp.busy)
    else $error("arith unit started while busy");

endmodule

@@ rtl/hmrs_ram.sv @@
// ----------------------------------------------------------------------------
// hmrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hmrs_arith.sv @@
// ----------------------------------------------------------------------------
// hmrs_arith
// Shared restoring divide / square-root unit, one quotient or root bit per
// cycle through a single subtractor.
// ----------------------------------------------------------------------------
module hmrs_arith (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hmrs_pkg::arith_req_t   req,
  output hmrs_pkg::arith_rsp_t   rsp
);

  logic                            busy_r;
  logic                            done_r;
  hmrs_pkg::arith_op_t             op_r;
  logic [hmrs_pkg::ARITH_W-1:0]    a_r;
  logic [hmrs_pkg::DIVR_W-1:0]     b_r;
  logic [hmrs_pkg::ARITH_W-1:0]    q_r;
  logic [hmrs_pkg::REM_W-1:0]      rem_r;
  logic [6:0]                      cnt_r;

  logic [hmrs_pkg::REM_W:0]        left;
  logic [hmrs_pkg::REM_W:0]        right;
  logic [hmrs_pkg::REM_W+1:0]      diff;
  logic                            take;

  always_comb begin
    if (op_r == hmrs_pkg::OP_DIV) begin
      left  = {rem_r, a_r[hmrs_pkg::ARITH_W-1]};
      right = {3'b000, b_r};
    end else begin
      left  = {rem_r[hmrs_pkg::REM_W-2:0], a_r[hmrs_pkg::ARITH_W-1 -: 2]};
      right = {1'b0, q_r[31:0], 2'b01};
    end
    diff = {1'b0, left} - {1'b0, right};
    take = !diff[hmrs_pkg::REM_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == hmrs_pkg::OP_DIV) ? 7'd64 : 7'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      a_r   <= req.a;
      b_r   <= req.b;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[hmrs_pkg::REM_W-1:0] : left[hmrs_pkg::REM_W-1:0];
      q_r   <= {q_r[hmrs_pkg::ARITH_W-2:0], take};
      a_r   <= (op_r == hmrs_pkg::OP_DIV) ? {a_r[hmrs_pkg::ARITH_W-2:0], 1'b0}
                                          : {a_r[hmrs_pkg::ARITH_W-3:0], 2'b00};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = rem_r;

endmodule
